### src/cpm_pkg.sv
// Shared types and constants for the connected prefix match table.
`timescale 1ns / 1ps

package cpm_pkg;

	// Table depth and the width of an entry address
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Largest IPv4 length the 6-bit store holds
	localparam logic [7:0] V4_LEN_MAX = 8'd63;

	typedef enum logic [1:0] {
		MODE_ADDR   = 2'd0,
		MODE_STATUS = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FAM_NONE = 2'd0,
		FAM_V4   = 2'd1,
		FAM_V6   = 2'd2
	} family_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_PUSH
	} state_t;

	// One table entry as stored in the memory
	typedef struct packed {
		logic        up;
		logic [31:0] if_index;
		logic [31:0] v4_addr;
		logic [5:0]  v4_len;
		logic [63:0] v6_high;
		logic [63:0] v6_low;
		logic [7:0]  v6_len;
	} entry_t;

endpackage

### src/cpm_table.sv
// Entry memory with one read and one write port and per-entry valid bits.
`timescale 1ns / 1ps

module cpm_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [cpm_pkg::IDX_W-1:0] rd_addr,
	output cpm_pkg::entry_t          rd_data,
	input  logic                     wr_en,
	input  logic [cpm_pkg::IDX_W-1:0] wr_addr,
	input  cpm_pkg::entry_t          wr_data
);

	cpm_pkg::entry_t                    mem [cpm_pkg::ENTRIES];
	logic [cpm_pkg::ENTRIES-1:0]        valid_q;
	cpm_pkg::entry_t                    rd_word_q;
	logic                               rd_valid_q;

	// Write the entry array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Track written entries; reset marks all of them empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// An entry never written reads as all zero
	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

### src/cpm_match.sv
// Prefix containment check of a query address against one table entry.
`timescale 1ns / 1ps

module cpm_match (
	input  cpm_pkg::entry_t entry,
	input  logic [1:0]      family,
	input  logic [63:0]     addr_high,
	input  logic [63:0]     addr_low,
	output logic            hit
);

	logic [31:0]  v4_mask;
	logic [127:0] v6_mask;
	logic         v4_ok;
	logic         v6_ok;

	// Build the prefix masks from the stored lengths
	assign v4_mask = ~(32'hFFFF_FFFF >> entry.v4_len);
	assign v6_mask = ~({128{1'b1}} >> entry.v6_len);

	// Skip empty prefixes and lengths beyond the address width
	assign v4_ok = (entry.v4_len != 6'd0) && (entry.v4_len <= 6'd32) &&
	               (((entry.v4_addr ^ addr_low[31:0]) & v4_mask) == 32'd0);
	assign v6_ok = (entry.v6_len != 8'd0) && (entry.v6_len <= 8'd128) &&
	               ((({entry.v6_high, entry.v6_low} ^ {addr_high, addr_low}) & v6_mask)
	                == 128'd0);

	// Select by family; only up entries count
	always_comb begin
		unique case (cpm_pkg::family_t'(family))
			cpm_pkg::FAM_V4: hit = entry.up && v4_ok;
			cpm_pkg::FAM_V6: hit = entry.up && v6_ok;
			default:         hit = 1'b0;
		endcase
	end

endmodule

### src/connected_prefix_match_table.sv
// Top level: item control, table walk and result register.
// Connected prefix match table.
// Input channel (valid/ready) carries one item: mode, slot, family, address,
// prefix length, link flag and interface index. Mode 0 loads the IPv4 or IPv6
// record of a slot, mode 1 loads its up flag and interface index, mode 2
// queries. Only queries give a result on the output channel: found and the
// interface index of the lowest-numbered up entry whose prefix holds the address.
// A write item reads the entry, then writes the merged entry back.
// A query walks the entry memory one entry per cycle from entry 0 and stops at
// the first hit, then loads the result register and returns to idle to take the
// next item. A query with family none walks no entry and loads its result
// directly. The walk rate is set by the single read port of the entry memory.
// Mode 3 is accepted and dropped.
// Reset clears the valid bits of all entries at once, so the table reads empty
// with no clearing pass, and drops any item in flight.
// The result sits in an output register; the next item is taken while it waits.
// When the receiver stalls with a result still held, a finished query holds its
// answer and accepts no further item until the output register frees.
`timescale 1ns / 1ps

module connected_prefix_match_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  slot,
	input  logic [1:0]  family,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic [7:0]  prefix_length,
	input  logic        link_up,
	input  logic [31:0] interface_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] match_index
);

	localparam logic [cpm_pkg::IDX_W-1:0] LAST_IDX = cpm_pkg::IDX_W'(cpm_pkg::ENTRIES - 1);

	cpm_pkg::state_t          state_q, state_d;
	logic [cpm_pkg::IDX_W-1:0] idx_q, idx_d;

	// Latched item payload
	logic [1:0]  mode_q, family_q;
	logic [cpm_pkg::IDX_W-1:0] slot_q;
	logic [63:0] high_q, low_q;
	logic [7:0]  plen_q;
	logic        link_q;
	logic [31:0] ifidx_q;

	// Pending result and output register
	logic        res_found_q, res_found_d;
	logic [31:0] res_index_q, res_index_d;
	logic        out_valid_q;
	logic        found_q;
	logic [31:0] match_index_q;

	// Memory port signals
	logic                     rd_en, wr_en;
	logic [cpm_pkg::IDX_W-1:0] rd_addr;
	cpm_pkg::entry_t          rd_data, wr_data;
	logic                     hit;
	logic                     accept, slot_ok, push;

	assign accept  = in_valid && in_ready;
	assign slot_ok = {5'd0, slot} < 9'(cpm_pkg::ENTRIES);

	cpm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (slot_q),
		.wr_data (wr_data)
	);

	cpm_match u_match (
		.entry     (rd_data),
		.family    (family_q),
		.addr_high (high_q),
		.addr_low  (low_q),
		.hit       (hit)
	);

	// Merge the latched write into the entry read back
	always_comb begin
		wr_data = rd_data;
		unique case (cpm_pkg::mode_t'(mode_q))
			cpm_pkg::MODE_ADDR: begin
				if (cpm_pkg::family_t'(family_q) == cpm_pkg::FAM_V4) begin
					wr_data.v4_addr = low_q[31:0];
					wr_data.v4_len  = (plen_q > cpm_pkg::V4_LEN_MAX) ?
					                  cpm_pkg::V4_LEN_MAX[5:0] : plen_q[5:0];
				end else begin
					wr_data.v6_high = high_q;
					wr_data.v6_low  = low_q;
					wr_data.v6_len  = plen_q;
				end
			end
			default: begin
				wr_data.up       = link_q;
				wr_data.if_index = ifidx_q;
			end
		endcase
	end

	// Next state, memory control and result capture
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		res_found_d = res_found_q;
		res_index_d = res_index_q;
		in_ready    = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = idx_q;
		wr_en       = 1'b0;
		push        = 1'b0;
		unique case (state_q)
			cpm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (mode)
						cpm_pkg::MODE_ADDR: begin
							if (slot_ok && (family == cpm_pkg::FAM_V4 ||
							                family == cpm_pkg::FAM_V6)) begin
								rd_en   = 1'b1;
								rd_addr = cpm_pkg::IDX_W'({28'd0, slot});
								state_d = cpm_pkg::ST_WRITE;
							end
						end
						cpm_pkg::MODE_STATUS: begin
							if (slot_ok) begin
								rd_en   = 1'b1;
								rd_addr = cpm_pkg::IDX_W'({28'd0, slot});
								state_d = cpm_pkg::ST_WRITE;
							end
						end
						cpm_pkg::MODE_QUERY: begin
							res_found_d = 1'b0;
							res_index_d = 32'd0;
							if (family == cpm_pkg::FAM_V4 || family == cpm_pkg::FAM_V6) begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								state_d = cpm_pkg::ST_SCAN;
							end else begin
								state_d = cpm_pkg::ST_PUSH;
							end
						end
						default: ;
					endcase
				end
			end
			cpm_pkg::ST_WRITE: begin
				wr_en   = 1'b1;
				state_d = cpm_pkg::ST_IDLE;
			end
			cpm_pkg::ST_SCAN: begin
				// Check the entry read last cycle; fetch the next one if the walk goes on
				if (hit) begin
					res_found_d = 1'b1;
					res_index_d = rd_data.if_index;
					state_d     = cpm_pkg::ST_PUSH;
				end else if (idx_q == LAST_IDX) begin
					state_d = cpm_pkg::ST_PUSH;
				end else begin
					idx_d   = idx_q + cpm_pkg::IDX_W'(1);
					rd_en   = 1'b1;
					rd_addr = idx_q + cpm_pkg::IDX_W'(1);
				end
			end
			cpm_pkg::ST_PUSH: begin
				if (!out_valid_q || out_ready) begin
					push    = 1'b1;
					state_d = cpm_pkg::ST_IDLE;
				end
			end
			default: state_d = cpm_pkg::ST_IDLE;
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch payload, walk index and results
	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		res_found_q <= res_found_d;
		res_index_q <= res_index_d;
		if (accept) begin
			mode_q   <= mode;
			family_q <= family;
			slot_q   <= cpm_pkg::IDX_W'({28'd0, slot});
			high_q   <= addr_high;
			low_q    <= addr_low;
			plen_q   <= prefix_length;
			link_q   <= link_up;
			ifidx_q  <= interface_index;
		end
		if (push) begin
			found_q       <= res_found_q;
			match_index_q <= res_index_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign match_index = match_index_q;

endmodule
